### src/chst_pkg.sv
// ----------------------------------------------------------------------------
// Channel hit streak tracker package
// Shared widths, codes and defaults for the tracker and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package chst_pkg;

	localparam int CHANNEL_W = 10;
	localparam int YIELD_W   = 16;
	localparam int RESULT_W  = 32;

	localparam int NUM_CHANNELS_DEF = 1024;
	localparam int COUNT_BITS_DEF   = 32;

	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;

	localparam logic [APB_ADDR_W-1:0] REG_HIT_THRESHOLD = 2'd0;
	localparam logic [YIELD_W-1:0]    HIT_THRESHOLD_RST = 16'd10;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_REPORT = 1'b1;

endpackage

`default_nettype wire

### src/chst_if.sv
// ----------------------------------------------------------------------------
// Channel hit streak tracker channels
// Valid/ready request channel for items and result channel for reports.
// ----------------------------------------------------------------------------
`default_nettype none

interface chst_item_if import chst_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 action;
	logic [CHANNEL_W-1:0] channel;
	logic [YIELD_W-1:0]   yield_value;

	modport source (output valid, action, channel, yield_value, input ready);
	modport sink   (input valid, action, channel, yield_value, output ready);
endinterface

interface chst_result_if import chst_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CHANNEL_W-1:0] report_channel;
	logic [RESULT_W-1:0]  longest_hit_run;
	logic [RESULT_W-1:0]  longest_miss_run;
	logic [RESULT_W-1:0]  hit_total;

	modport source (output valid, report_channel, longest_hit_run, longest_miss_run,
		hit_total, input ready);
	modport sink   (input valid, report_channel, longest_hit_run, longest_miss_run,
		hit_total, output ready);
endinterface

`default_nettype wire

### src/channel_hit_streak_tracker.sv
// ----------------------------------------------------------------------------
// Channel hit streak tracker
// Per-channel hit and miss run statistics kept in one memory.
// ----------------------------------------------------------------------------
// Items arrive on the item channel. A sample request updates the runs of its
// channel; a report request returns the longest hit run, longest miss run and
// hit total of its channel on the result channel and clears that channel.
// The hit threshold is written through the APB port at address 0.
// Each request reads the channel entry from the memory in the cycle after it
// is accepted and writes it back at the end of that cycle, so one request is
// taken every cycle while no report is stalled; back-to-back requests to one
// channel are forwarded from the last write. A report goes from the read stage
// to the output register, which drives the result channel and holds it; while
// it is stalled a second report waits in the read stage and item ready drops.
// After reset all NUM_CHANNELS memory entries are cleared one entry per cycle,
// with item ready low; configuration writes are taken during that time.
// ----------------------------------------------------------------------------
`default_nettype none

module channel_hit_streak_tracker import chst_pkg::*; #(
	parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
	parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	chst_item_if.sink                  item,
	chst_result_if.source              result
);

	localparam int AW      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CB      = COUNT_BITS;
	localparam int ENTRY_W = 5 * CB;

	logic [YIELD_W-1:0] thr_q;

	logic          clr_active_q;
	logic [AW-1:0] clr_cnt_q;

	logic                 valid_s1;
	logic                 act_s1;
	logic                 hit_s1;
	logic                 in_range_s1;
	logic [CHANNEL_W-1:0] ch_s1;
	logic [AW-1:0]        addr_s1;

	logic               wb_vld_q;
	logic [AW-1:0]      wb_addr_q;
	logic [ENTRY_W-1:0] wb_data_q;

	logic                 out_valid_q;
	logic [CHANNEL_W-1:0] out_ch_q;
	logic [CB-1:0]        out_hit_q;
	logic [CB-1:0]        out_miss_q;
	logic [CB-1:0]        out_total_q;

	logic               accept;
	logic               stall_s1;
	logic               fire_s1;
	logic [31:0]        ch_ext;
	logic               in_range;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [ENTRY_W-1:0] mem_rdata;
	logic [ENTRY_W-1:0] entry;
	logic [ENTRY_W-1:0] entry_new;

	logic [CB-1:0] cur_hit, cur_miss, max_hit, max_miss, hit_cnt;
	logic [CB-1:0] fold_hit, fold_miss;
	logic [CB-1:0] inc_hit, inc_miss, inc_cnt;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = (paddr == REG_HIT_THRESHOLD) ? APB_DATA_W'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= HIT_THRESHOLD_RST;
		end else if (psel && penable && pwrite && pready && paddr == REG_HIT_THRESHOLD) begin
			thr_q <= pwdata[YIELD_W-1:0];
		end
	end

	// Request handshake and read stage.
	assign stall_s1 = valid_s1 && act_s1 == ACT_REPORT && out_valid_q && !result.ready;
	assign fire_s1  = valid_s1 && !stall_s1;
	assign item.ready = !clr_active_q && !stall_s1;
	assign accept   = item.valid && item.ready;
	assign ch_ext   = 32'(item.channel);
	assign in_range = ch_ext < 32'(NUM_CHANNELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1      <= item.action;
			hit_s1      <= item.yield_value > thr_q;
			in_range_s1 <= in_range;
			ch_s1       <= item.channel;
			addr_s1     <= ch_ext[AW-1:0];
		end
	end

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else if (clr_active_q) begin
			if (clr_cnt_q == AW'(NUM_CHANNELS - 1)) begin
				clr_active_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	chst_ram #(
		.DEPTH  (NUM_CHANNELS),
		.WIDTH  (ENTRY_W),
		.ADDR_W (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (ch_ext[AW-1:0]),
		.rdata (mem_rdata)
	);

	// The last write always holds the newest value of its entry.
	assign entry = (wb_vld_q && wb_addr_q == addr_s1) ? wb_data_q : mem_rdata;

	assign cur_hit  = entry[0*CB +: CB];
	assign cur_miss = entry[1*CB +: CB];
	assign max_hit  = entry[2*CB +: CB];
	assign max_miss = entry[3*CB +: CB];
	assign hit_cnt  = entry[4*CB +: CB];

	assign fold_hit  = (cur_hit > max_hit) ? cur_hit : max_hit;
	assign fold_miss = (cur_miss > max_miss) ? cur_miss : max_miss;
	assign inc_hit   = (cur_hit == '1) ? cur_hit : cur_hit + 1'b1;
	assign inc_miss  = (cur_miss == '1) ? cur_miss : cur_miss + 1'b1;
	assign inc_cnt   = (hit_cnt == '1) ? hit_cnt : hit_cnt + 1'b1;

	always_comb begin
		entry_new = '0;
		if (act_s1 == ACT_SAMPLE) begin
			if (hit_s1) begin
				entry_new = {inc_cnt, fold_miss, max_hit, {CB{1'b0}}, inc_hit};
			end else begin
				entry_new = {hit_cnt, max_miss, fold_hit, inc_miss, {CB{1'b0}}};
			end
		end
	end

	always_comb begin
		if (clr_active_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else begin
			mem_we    = fire_s1 && in_range_s1;
			mem_waddr = addr_s1;
			mem_wdata = entry_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_vld_q <= 1'b0;
		end else if (mem_we) begin
			wb_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			wb_addr_q <= mem_waddr;
			wb_data_q <= mem_wdata;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && act_s1 == ACT_REPORT) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && act_s1 == ACT_REPORT) begin
			out_ch_q    <= ch_s1;
			out_hit_q   <= in_range_s1 ? fold_hit : '0;
			out_miss_q  <= in_range_s1 ? fold_miss : '0;
			out_total_q <= in_range_s1 ? hit_cnt : '0;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.report_channel   = out_ch_q;
	assign result.longest_hit_run  = RESULT_W'(out_hit_q);
	assign result.longest_miss_run = RESULT_W'(out_miss_q);
	assign result.hit_total        = RESULT_W'(out_total_q);

	// A report that leaves the read stage is presented in the next cycle.
	a_report_presented: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && act_s1 == ACT_REPORT) |=> result.valid)
		else $error("report lost on its way to the result register");

	// A stalled read stage must not write its entry back.
	a_no_write_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(stall_s1 && !clr_active_q) |-> !mem_we)
		else $error("memory written while the read stage is stalled");

	// Out-of-range channels never touch the memory.
	a_range_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !in_range_s1 && !clr_active_q) |-> !mem_we)
		else $error("memory written for an out-of-range channel");

	// The clearing pass ends only after the last entry was written.
	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_active_q) |-> $past(clr_cnt_q) == AW'(NUM_CHANNELS - 1))
		else $error("clearing pass ended early");

endmodule

`default_nettype wire

### src/chst_ram.sv
// ----------------------------------------------------------------------------
// Channel statistics memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module chst_ram #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 160,
	parameter int ADDR_W = 10
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
